/* src/sbd_pkg.sv */
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types and constants for the SBUS frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sbd_pkg;

  localparam int unsigned FrameBytes = 25;
  localparam int unsigned Channels   = 16;
  localparam int unsigned ChanBits   = 11;
  localparam int unsigned PackBytes  = 22;   // bytes 1..22 carry channels
  localparam int unsigned PackBits   = PackBytes * 8;
  localparam int unsigned PosBits    = 5;
  localparam int unsigned IdxBits    = 4;
  localparam int unsigned ProdBits   = 21;   // 2047 * 1000 fits
  localparam int unsigned DivSteps   = ProdBits;
  localparam int unsigned CntBits    = 5;

  localparam logic [PosBits-1:0] PosFlags = 5'd23;
  localparam logic [PosBits-1:0] PosLast  = 5'(FrameBytes - 1);
  localparam logic [IdxBits-1:0] IdxLast  = 4'(Channels - 1);
  localparam logic [10:0]        FullScale = 11'd1000;

  // register indexes
  localparam logic [2:0] RegHeader   = 3'd0;
  localparam logic [2:0] RegMin      = 3'd1;
  localparam logic [2:0] RegMid      = 3'd2;
  localparam logic [2:0] RegMax      = 3'd3;
  localparam logic [2:0] RegDeadzone = 3'd4;

  localparam logic [7:0]  HeaderRst   = 8'd15;
  localparam logic [10:0] MinRst      = 11'd172;
  localparam logic [10:0] MidRst      = 11'd992;
  localparam logic [10:0] MaxRst      = 11'd1811;
  localparam logic [9:0]  DeadzoneRst = 10'd20;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_START,
    S_DIV,
    S_STORE,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MAP_ZERO,
    MAP_POS_SAT,
    MAP_NEG_SAT,
    MAP_DIVIDE
  } map_kind_e;

  typedef struct packed {
    logic               shift_byte;
    logic               load_flags;
    logic               count_inc;
    logic               map_start;
    logic               map_sel;     // 0 steering, 1 throttle
    logic               div_step;
    logic               map_store;
    logic               out_load;
    logic [IdxBits-1:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic hdr_match;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

/* src/sbd_ifs.sv */
// ----------------------------------------------------------------------------
// sbd_ifs
// Request channels of the SBUS frame decoder: byte in, result out, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbd_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel_index;
  logic [10:0]        raw_value;
  logic               is_last;
  logic signed [10:0] steering;
  logic signed [10:0] throttle;
  logic               manual_ctl;
  logic               estop;
  logic               digital_a;
  logic               digital_b;
  logic               link_lost;
  logic               failsafe;
  logic [31:0]        frame_count;
  modport source (output valid, output channel_index, output raw_value, output is_last,
                  output steering, output throttle, output manual_ctl, output estop,
                  output digital_a, output digital_b, output link_lost,
                  output failsafe, output frame_count, input ready);
  modport sink   (input valid, input channel_index, input raw_value, input is_last,
                  input steering, input throttle, input manual_ctl, input estop,
                  input digital_a, input digital_b, input link_lost,
                  input failsafe, input frame_count, output ready);
endinterface

interface sbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/sbus_frame_decoder.sv */
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// SBUS 25-byte frame decoder with steering/throttle mapping.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while collecting; bytes before a header are
// dropped. The final byte starts the mapping of channels 0 and 1, one after
// the other, each through a setup state, a bit-serial restoring divider and a
// store state. The 16 channel results then leave at one per cycle when the
// sink is ready. Input reopens the cycle after the sixteenth result is taken,
// so sink stalls also hold off the bytes of the next frame.
`default_nettype none

module sbus_frame_decoder (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  sbd_byte_if.sink   in_if,
  sbd_result_if.source out_if,
  sbd_cfg_if.sink    cfg_if
);

  sbd_pkg::cmd_t    cmd;
  sbd_pkg::status_t status;
  logic [3:0]       flags;

  assign cfg_if.ready = 1'b1;

  sbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sbd_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_if.valid),
    .cfg_index_i     (cfg_if.index),
    .cfg_data_i      (cfg_if.data),
    .rx_byte_i       (in_if.rx_byte),
    .cmd_i           (cmd),
    .status_o        (status),
    .channel_index_o (out_if.channel_index),
    .raw_value_o     (out_if.raw_value),
    .is_last_o       (out_if.is_last),
    .steering_o      (out_if.steering),
    .throttle_o      (out_if.throttle),
    .manual_ctl_o    (out_if.manual_ctl),
    .estop_o         (out_if.estop),
    .flags_o         (flags),
    .frame_count_o   (out_if.frame_count)
  );

  assign out_if.digital_a = flags[0];
  assign out_if.digital_b = flags[1];
  assign out_if.link_lost = flags[2];
  assign out_if.failsafe  = flags[3];

endmodule

`default_nettype wire

/* src/sbd_ctrl.sv */
// ----------------------------------------------------------------------------
// sbd_ctrl
// Frame sequencer: byte position, mapping sequence and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  input  wire sbd_pkg::status_t status_i,
  output      sbd_pkg::cmd_t  cmd_o
);

  sbd_pkg::state_e state_q, state_d;
  logic [sbd_pkg::PosBits-1:0] pos_q, pos_d;
  logic [sbd_pkg::IdxBits-1:0] k_q, k_d;
  logic sel_q, sel_d;
  logic out_valid_q, out_valid_d;
  logic in_acc, out_load;

  // bytes wait until the last result of the previous frame has left
  assign in_acc   = in_valid_i && (state_q == sbd_pkg::S_COLLECT) && !out_valid_q;
  assign out_load = (state_q == sbd_pkg::S_EMIT) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    sel_d   = sel_q;
    k_d     = k_q;
    unique case (state_q)
      sbd_pkg::S_COLLECT: begin
        if (in_acc) begin
          if (pos_q == '0) begin
            if (status_i.hdr_match) pos_d = 5'd1;
          end else if (pos_q == sbd_pkg::PosLast) begin
            pos_d   = '0;
            sel_d   = 1'b0;
            state_d = sbd_pkg::S_START;
          end else begin
            pos_d = pos_q + 5'd1;
          end
        end
      end
      sbd_pkg::S_START: state_d = sbd_pkg::S_DIV;
      sbd_pkg::S_DIV:   if (status_i.div_last) state_d = sbd_pkg::S_STORE;
      sbd_pkg::S_STORE: begin
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = sbd_pkg::S_START;
        end else begin
          k_d     = '0;
          state_d = sbd_pkg::S_EMIT;
        end
      end
      sbd_pkg::S_EMIT: begin
        if (out_load) begin
          k_d = k_q + 4'd1;
          if (k_q == sbd_pkg::IdxLast) state_d = sbd_pkg::S_COLLECT;
        end
      end
      default: state_d = sbd_pkg::S_COLLECT;
    endcase
  end

  // output valid tracks loads and takes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  // commands
  always_comb begin
    cmd_o = '0;
    cmd_o.map_sel = sel_q;
    cmd_o.out_idx = k_q;
    in_ready_o    = (state_q == sbd_pkg::S_COLLECT) && !out_valid_q;
    if (in_acc && pos_q != '0) begin
      cmd_o.shift_byte = (pos_q < sbd_pkg::PosFlags);
      cmd_o.load_flags = (pos_q == sbd_pkg::PosFlags);
      cmd_o.count_inc  = (pos_q == sbd_pkg::PosLast);
    end
    cmd_o.map_start = (state_q == sbd_pkg::S_START);
    cmd_o.div_step  = (state_q == sbd_pkg::S_DIV);
    cmd_o.map_store = (state_q == sbd_pkg::S_STORE);
    cmd_o.out_load  = out_load;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbd_pkg::S_COLLECT;
      pos_q       <= '0;
      k_q         <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* src/sbd_datapath.sv */
// ----------------------------------------------------------------------------
// sbd_datapath
// Config registers, frame store, stick mapping divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [10:0]       cfg_data_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire sbd_pkg::cmd_t     cmd_i,
  output      sbd_pkg::status_t  status_o,
  output      logic [3:0]        channel_index_o,
  output      logic [10:0]       raw_value_o,
  output      logic              is_last_o,
  output      logic signed [10:0] steering_o,
  output      logic signed [10:0] throttle_o,
  output      logic              manual_ctl_o,
  output      logic              estop_o,
  output      logic [3:0]        flags_o,
  output      logic [31:0]       frame_count_o
);

  logic [7:0]  header_q;
  logic [10:0] min_q, mid_q, max_q;
  logic [9:0]  dz_q;

  logic [sbd_pkg::PackBits-1:0] chan_q;
  logic [3:0]  flags_q;
  logic [31:0] count_q;
  logic        manual_q, estop_q;
  logic signed [10:0] steer_q, thr_q;

  sbd_pkg::map_kind_e kind_q, kind_d;
  logic        neg_q, neg_d;
  logic [10:0] dvs_q;
  logic [10:0] rem_q, rem_d;
  logic [sbd_pkg::ProdBits-1:0] quo_q;
  logic [sbd_pkg::CntBits-1:0]  cnt_q;

  logic [3:0]  idx_q;
  logic [10:0] raw_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= sbd_pkg::HeaderRst;
      min_q    <= sbd_pkg::MinRst;
      mid_q    <= sbd_pkg::MidRst;
      max_q    <= sbd_pkg::MaxRst;
      dz_q     <= sbd_pkg::DeadzoneRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sbd_pkg::RegHeader:   header_q <= cfg_data_i[7:0];
        sbd_pkg::RegMin:      min_q    <= cfg_data_i;
        sbd_pkg::RegMid:      mid_q    <= cfg_data_i;
        sbd_pkg::RegMax:      max_q    <= cfg_data_i;
        sbd_pkg::RegDeadzone: dz_q     <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // map setup: offset from center, deadzone, span and magnitudes
  logic [10:0]        raw_sel;
  logic signed [11:0] v, dz, span;
  logic [10:0]        mag_v, mag_s;
  logic [sbd_pkg::ProdBits-1:0] prod;

  always_comb begin
    raw_sel = cmd_i.map_sel ? chan_q[2*sbd_pkg::ChanBits-1 -: sbd_pkg::ChanBits]
                            : chan_q[sbd_pkg::ChanBits-1:0];
    v    = signed'({1'b0, raw_sel}) - signed'({1'b0, mid_q});
    dz   = signed'({2'b00, dz_q});
    span = (v > 12'sd0) ? signed'({1'b0, max_q}) - signed'({1'b0, mid_q})
                        : signed'({1'b0, mid_q}) - signed'({1'b0, min_q});
    mag_v = v[11] ? 11'(-v) : v[10:0];
    mag_s = span[11] ? 11'(-span) : span[10:0];
    prod  = 21'({10'd0, mag_v} * 21'd1000);
    neg_d = v[11] ^ span[11];
    if ((v > -dz && v < dz) || v == 12'sd0) begin
      kind_d = sbd_pkg::MAP_ZERO;
    end else if (span == 12'sd0) begin
      kind_d = v[11] ? sbd_pkg::MAP_NEG_SAT : sbd_pkg::MAP_POS_SAT;
      neg_d  = v[11];
    end else begin
      kind_d = sbd_pkg::MAP_DIVIDE;
    end
  end

  // one restoring divide step per cycle
  logic [11:0] trial;
  logic        ge;
  always_comb begin
    trial = {rem_q, quo_q[sbd_pkg::ProdBits-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? 11'(trial - {1'b0, dvs_q}) : trial[10:0];
  end

  assign status_o.div_last  = (cnt_q == 5'(sbd_pkg::DivSteps - 1));
  assign status_o.hdr_match = (rx_byte_i == header_q);

  // final value: clamp magnitude, apply sign
  logic [10:0] qmag;
  logic signed [10:0] mapped;
  always_comb begin
    unique case (kind_q)
      sbd_pkg::MAP_ZERO:    qmag = '0;
      sbd_pkg::MAP_POS_SAT,
      sbd_pkg::MAP_NEG_SAT: qmag = sbd_pkg::FullScale;
      sbd_pkg::MAP_DIVIDE:  qmag = (quo_q > 21'(sbd_pkg::FullScale)) ? sbd_pkg::FullScale
                                                                       : quo_q[10:0];
      default:              qmag = '0;
    endcase
    mapped = neg_q ? signed'(11'(-qmag)) : signed'(qmag);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_start) begin
      kind_q <= kind_d;
      neg_q  <= neg_d;
      dvs_q  <= mag_s;
      rem_q  <= '0;
      quo_q  <= prod;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[sbd_pkg::ProdBits-2:0], ge};
      cnt_q <= cnt_q + 5'd1;
    end
  end

  // frame store: channels shift in from the top, flags kept apart
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_byte) begin
      chan_q <= {rx_byte_i, chan_q[sbd_pkg::PackBits-1:8]};
    end else if (cmd_i.out_load) begin
      chan_q <= {{sbd_pkg::ChanBits{1'b0}}, chan_q[sbd_pkg::PackBits-1:sbd_pkg::ChanBits]};
    end
    if (cmd_i.load_flags) flags_q <= rx_byte_i[3:0];
    // switches, taken once per frame before the store shifts out
    if (cmd_i.map_start && !cmd_i.map_sel) begin
      manual_q <= chan_q[5*sbd_pkg::ChanBits-1 -: sbd_pkg::ChanBits] > mid_q;
      estop_q  <= (chan_q[6*sbd_pkg::ChanBits-1 -: sbd_pkg::ChanBits] > mid_q) || flags_q[3];
    end
    if (cmd_i.map_store) begin
      if (cmd_i.map_sel) thr_q   <= mapped;
      else               steer_q <= mapped;
    end
    if (cmd_i.out_load) begin
      idx_q <= cmd_i.out_idx;
      raw_q <= chan_q[sbd_pkg::ChanBits-1:0];
    end
  end

  // completed frame counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              count_q <= '0;
    else if (cmd_i.count_inc) count_q <= count_q + 32'd1;
  end

  assign channel_index_o = idx_q;
  assign raw_value_o     = raw_q;
  assign is_last_o       = (idx_q == sbd_pkg::IdxLast);
  assign steering_o      = steer_q;
  assign throttle_o      = thr_q;
  assign manual_ctl_o    = manual_q;
  assign estop_o         = estop_q;
  assign flags_o         = flags_q;
  assign frame_count_o   = count_q;

endmodule

`default_nettype wire

/* src/sbd_checker.sv */
// ----------------------------------------------------------------------------
// sbd_checker
// Port-level checks for the SBUS frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_last,
  input wire logic [3:0]  out_idx,
  input wire logic [10:0] out_steer,
  input wire logic        in_ready
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // results of a frame follow back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=> out_valid && !in_ready)
    else $error("gap inside result burst");

  // channel index counts up within a frame
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=> out_idx == $past(out_idx) + 4'd1)
    else $error("channel index out of order");

  // steering stays within full scale
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ($signed(out_steer) >= -11'sd1000) && ($signed(out_steer) <= 11'sd1000))
    else $error("steering out of range");

endmodule

bind sbus_frame_decoder sbd_checker u_sbd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_last  (out_if.is_last),
  .out_idx   (out_if.channel_index),
  .out_steer (out_if.steering),
  .in_ready  (in_if.ready)
);

`default_nettype wire
